// ===== hw/rtl/gnpm_pkg.sv =====
// types, constants and codes shared by the greedy nearest point matcher
package gnpm_pkg;

	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 12;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
	localparam int DIST_BITS  = 25;
	localparam int INDEX_OUT_BITS = 8;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int CMP_BITS   = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0]  dist_t;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_MATCH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic   used;
		coord_t x;
		coord_t y;
	} ref_entry_t;

endpackage

// ===== hw/rtl/gnpm_ram.sv =====
// generic single port write, single port read ram with registered read data
module gnpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/greedy_nearest_point_matcher.sv =====
// top level of the greedy nearest point matcher
//
// command channel: a transaction is taken at a rising edge with start high and
// busy low. action clear empties the reference list, load appends one point
// (ignored once the list is full), match searches the list for the query.
// clear and load finish in the accept cycle and leave busy low.
// a match raises busy while it scans the point ram, one ram read per stored
// point and one entry per cycle, then drains two pipeline stages (square,
// compare) and ends with one cycle in which result_strobe is high with the
// result, while the winning entry is written back marked used.
// the receiver cannot stall: the result must be taken in its strobe cycle.
// configuration: cfg_ready is always high, a transaction with cfg_valid
// writes max_dist_sq; write it only while idle.
// reset: arst_n low empties the list, clears max_dist_sq and returns the block
// to idle at once; no clearing pass is needed, each load writes its used mark
module greedy_nearest_point_matcher (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [1:0]                              action,
	input  gnpm_pkg::coord_t                        point_x,
	input  gnpm_pkg::coord_t                        point_y,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  gnpm_pkg::dist_t                         cfg_data,
	output logic                                    result_strobe,
	output logic                                    matched,
	output gnpm_pkg::coord_t                        query_x,
	output gnpm_pkg::coord_t                        query_y,
	output logic [gnpm_pkg::INDEX_OUT_BITS-1:0]     ref_index,
	output gnpm_pkg::coord_t                        ref_x,
	output gnpm_pkg::coord_t                        ref_y
);

	import gnpm_pkg::*;

	state_t              state_q, state_d;
	dist_t               max_dist_sq_q;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] rd_addr_q;
	coord_t              qx_q, qy_q;

	logic                best_found_q;
	logic [CMP_BITS-1:0] best_q;
	logic [IDX_BITS-1:0] best_idx_q;
	coord_t              best_x_q, best_y_q;

	logic                v_s1;
	logic [IDX_BITS-1:0] idx_s1;
	logic                v_s2;
	logic                used_s2;
	logic [IDX_BITS-1:0] idx_s2;
	coord_t              x_s2, y_s2;
	logic [SQ_BITS-1:0]  sqx_s2, sqy_s2;

	logic                accept;
	action_t             act;
	logic                ram_we, ram_re;
	logic [IDX_BITS-1:0] ram_waddr;
	ref_entry_t          ram_wdata, ram_rdata;
	coord_t              dx, dy;
	logic [CMP_BITS-1:0] dist_sum;
	logic                better;

	assign act    = action_t'(action);
	assign accept = start && !busy;

	gnpm_ram #(
		.WIDTH($bits(ref_entry_t)),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr_q[IDX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && act == ACT_MATCH) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_addr_q >= count_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and ram control
	always_comb begin
		busy          = 1'b1;
		result_strobe = 1'b0;
		ram_re        = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = count_q[IDX_BITS-1:0];
		ram_wdata     = '{used: 1'b0, x: point_x, y: point_y};
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				ram_we = start && act == ACT_LOAD && count_q < CNT_BITS'(MAX_POINTS);
			end
			ST_SCAN: begin
				ram_re = rd_addr_q < count_q;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				result_strobe = 1'b1;
				ram_we        = best_found_q;
				ram_waddr     = best_idx_q;
				ram_wdata     = '{used: 1'b1, x: best_x_q, y: best_y_q};
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	assign matched   = best_found_q;
	assign query_x   = qx_q;
	assign query_y   = qy_q;
	assign ref_index = best_found_q ? INDEX_OUT_BITS'(best_idx_q) : '0;
	assign ref_x     = best_found_q ? best_x_q : '0;
	assign ref_y     = best_found_q ? best_y_q : '0;

	assign dx       = (qx_q >= ram_rdata.x) ? qx_q - ram_rdata.x : ram_rdata.x - qx_q;
	assign dy       = (qy_q >= ram_rdata.y) ? qy_q - ram_rdata.y : ram_rdata.y - qy_q;
	assign dist_sum = CMP_BITS'(sqx_s2) + CMP_BITS'(sqy_s2);
	assign better   = v_s2 && !used_s2 && dist_sum < best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_dist_sq_q <= '0;
			count_q       <= '0;
			rd_addr_q     <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			best_found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				max_dist_sq_q <= cfg_data;
			end
			if (state_q == ST_IDLE && accept) begin
				case (act)
					ACT_CLEAR: begin
						count_q <= '0;
					end
					ACT_LOAD: begin
						if (count_q < CNT_BITS'(MAX_POINTS)) begin
							count_q <= count_q + 1'b1;
						end
					end
					ACT_MATCH: begin
						rd_addr_q    <= '0;
						best_found_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (ram_re) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			v_s1 <= ram_re;
			v_s2 <= v_s1;
			if (better) begin
				best_found_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && act == ACT_MATCH) begin
			qx_q   <= point_x;
			qy_q   <= point_y;
			best_q <= CMP_BITS'(max_dist_sq_q);
		end
		idx_s1  <= rd_addr_q[IDX_BITS-1:0];
		idx_s2  <= idx_s1;
		used_s2 <= ram_rdata.used;
		x_s2    <= ram_rdata.x;
		y_s2    <= ram_rdata.y;
		sqx_s2  <= SQ_BITS'(dx) * SQ_BITS'(dx);
		sqy_s2  <= SQ_BITS'(dy) * SQ_BITS'(dy);
		if (better) begin
			best_q     <= dist_sum;
			best_idx_q <= idx_s2;
			best_x_q   <= x_s2;
			best_y_q   <= y_s2;
		end
	end

endmodule
